### rtl/core/csm_pkg.sv
// shared constants, codes and types for the cron schedule matcher
package csm_pkg;

    localparam int ENTRIES     = 16;
    localparam int LIST_SLOTS  = 4;
    localparam int FIELDS      = 5;
    localparam int MAX_VALUE   = 100;
    localparam int MAX_RESULTS = 16;

    localparam int VAL_W   = 7;
    localparam int CELLS   = ENTRIES * FIELDS;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int LADDR_W = $clog2(CELLS * LIST_SLOTS);
    localparam int SLOT_W  = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
    localparam int FILL_W  = $clog2(LIST_SLOTS + 1);
    localparam int SCAN_MAX = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;
    localparam int SCAN_W  = $clog2(SCAN_MAX + 1);
    localparam int FSEL_W  = 3;

    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] MODE_ANY   = 2'd0;
    localparam logic [1:0] MODE_EXACT = 2'd1;
    localparam logic [1:0] MODE_RANGE = 2'd2;
    localparam logic [1:0] MODE_LIST  = 2'd3;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_NOMATCH = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOT_LIST = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [VAL_W-1:0]  low;
        logic [VAL_W-1:0]  high;
        logic [FILL_W-1:0] fill;
    } cell_t;

    localparam int CELL_WORD_W = $bits(cell_t);

endpackage

### rtl/core/csm_ram.sv
// generic single write port ram with registered read
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### rtl/core/cron_schedule_matcher.sv
// cron schedule matcher top level: pattern table, scan sequencer and result register
// set write: the cell is written as the item is accepted; the acknowledge follows from the ACK state
// append write: cell read, then check and store, then acknowledge
// tick: each field checked reads and evaluates its cell, a list field reads its slots in turn, and each
//   matching entry passes a hit step; a failing field ends its entry; one item at a time
// reset clears the sequencer, the result register and active_entries; table memories are not cleared
module cron_schedule_matcher (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [4:0]                cfg_write_data,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                func,
    input  logic [3:0]                entry,
    input  logic [csm_pkg::FSEL_W-1:0] field_sel,
    input  logic [1:0]                mode,
    input  logic [csm_pkg::VAL_W-1:0] value_a,
    input  logic [csm_pkg::VAL_W-1:0] value_b,
    input  logic [5:0]                minute,
    input  logic [4:0]                hour,
    input  logic [4:0]                day,
    input  logic [3:0]                month,
    input  logic [2:0]                weekday,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [1:0]                kind,
    output logic [3:0]                match_entry,
    output logic [1:0]                status,
    output logic                      last
);
    import csm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK,
        ST_APP_RD,
        ST_APP_CHK,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_LIST_EV,
        ST_HIT,
        ST_FINISH
    } state_t;

    function automatic logic [LADDR_W-1:0] list_addr(input logic [CELL_W-1:0] c,
                                                      input logic [SLOT_W-1:0] s);
        return LADDR_W'(LADDR_W'(c) * LADDR_W'(LIST_SLOTS) + LADDR_W'(s));
    endfunction

    state_t              state_reg, state_next;
    logic [4:0]          active_reg;
    logic [3:0]          ent_in_reg, ent_in_next;
    logic [1:0]          stat_reg, stat_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [VAL_W-1:0]    va_reg, va_next;
    logic [VAL_W-1:0]    tvec_reg [FIELDS];
    logic [SCAN_W-1:0]   ent_reg, ent_next;
    logic [CELL_W-1:0]   base_reg, base_next;
    logic [FSEL_W-1:0]   field_reg, field_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                pend_reg, pend_next;
    logic [SCAN_W-1:0]   pend_ent_reg, pend_ent_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          kind_reg, kind_next;
    logic [3:0]          match_reg, match_next;
    logic [1:0]          status_reg, status_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                can_load;
    logic                cell_ok;
    logic [CELL_W-1:0]   in_cell;
    logic [VAL_W-1:0]    va_sat;
    logic [VAL_W-1:0]    vb_sat;
    logic [SCAN_W-1:0]   scan_limit;
    logic [CELL_W-1:0]   scan_cell;
    logic [VAL_W-1:0]    tv;
    logic [FILL_W-1:0]   slot_inc;
    logic                fld_pass;
    logic                fld_fail;

    logic                cram_we;
    logic [CELL_W-1:0]   cram_waddr;
    cell_t               cram_wdata;
    logic [CELL_W-1:0]   cram_raddr;
    cell_t               cram_rdata;
    logic                lram_we;
    logic [LADDR_W-1:0]  lram_waddr;
    logic [LADDR_W-1:0]  lram_raddr;
    logic [VAL_W-1:0]    lram_rdata;

    csm_ram #(.WIDTH(CELL_WORD_W), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cram_we),
        .waddr (cram_waddr),
        .wdata (cram_wdata),
        .raddr (cram_raddr),
        .rdata (cram_rdata)
    );

    csm_ram #(.WIDTH(VAL_W), .DEPTH(CELLS * LIST_SLOTS)) u_list_ram (
        .clk   (clk),
        .we    (lram_we),
        .waddr (lram_waddr),
        .wdata (va_reg),
        .raddr (lram_raddr),
        .rdata (lram_rdata)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign can_load     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign match_entry  = match_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    assign va_sat  = (value_a > VAL_W'(MAX_VALUE)) ? VAL_W'(MAX_VALUE) : value_a;
    assign vb_sat  = (value_b > VAL_W'(MAX_VALUE)) ? VAL_W'(MAX_VALUE) : value_b;
    assign cell_ok = (7'(entry) < 7'(ENTRIES)) && (field_sel < FSEL_W'(FIELDS));
    assign in_cell = CELL_W'(CELL_W'(entry) * CELL_W'(FIELDS) + CELL_W'(field_sel));

    assign scan_limit = (active_reg > 5'(SCAN_MAX)) ? SCAN_W'(SCAN_MAX) : SCAN_W'(active_reg);
    assign scan_cell  = CELL_W'(base_reg + CELL_W'(field_reg));
    assign tv         = tvec_reg[field_reg];
    assign slot_inc   = FILL_W'(FILL_W'(slot_reg) + FILL_W'(1));

    assign cram_raddr = (state_reg == ST_APP_RD) ? cell_reg : scan_cell;
    assign lram_raddr = (state_reg == ST_LIST_EV) ? list_addr(cell_reg, SLOT_W'(slot_inc))
                                                  : list_addr(cell_reg, SLOT_W'(0));
    assign lram_waddr = list_addr(cell_reg, SLOT_W'(cram_rdata.fill));

    // shared field compare
    always_comb
    begin
        fld_pass = 1'b0;
        fld_fail = 1'b0;
        if (state_reg == ST_SCAN_EV)
        begin
            case (cram_rdata.mode)
                MODE_ANY:   fld_pass = 1'b1;
                MODE_EXACT:
                begin
                    fld_pass = (cram_rdata.low == tv);
                    fld_fail = !fld_pass;
                end
                MODE_RANGE:
                begin
                    fld_pass = (cram_rdata.low <= tv) && (tv <= cram_rdata.high);
                    fld_fail = !fld_pass;
                end
                default:    fld_fail = (cram_rdata.fill == '0);
            endcase
        end
        else if (state_reg == ST_LIST_EV)
        begin
            fld_pass = (lram_rdata == tv);
            fld_fail = !fld_pass && !(slot_inc < fill_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ent_in_next    = ent_in_reg;
        stat_next      = stat_reg;
        cell_next      = cell_reg;
        va_next        = va_reg;
        ent_next       = ent_reg;
        base_next      = base_reg;
        field_next     = field_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        pend_ent_next  = pend_ent_reg;
        out_valid_next = out_valid_reg && result_stall;
        kind_next      = kind_reg;
        match_next     = match_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        cram_we        = 1'b0;
        cram_waddr     = cell_reg;
        cram_wdata     = cram_rdata;
        lram_we        = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                ent_in_next = entry;
                stat_next   = STAT_OK;
                cell_next   = in_cell;
                va_next     = va_sat;
                if (accept)
                begin
                    unique case (func)
                        FUNC_SET:
                        begin
                            cram_we         = cell_ok;
                            cram_waddr      = in_cell;
                            cram_wdata.mode = mode;
                            cram_wdata.low  = va_sat;
                            cram_wdata.high = vb_sat;
                            cram_wdata.fill = '0;
                            state_next      = ST_ACK;
                        end
                        FUNC_APPEND:
                        begin
                            state_next = cell_ok ? ST_APP_RD : ST_ACK;
                        end
                        FUNC_TICK:
                        begin
                            ent_next   = '0;
                            base_next  = '0;
                            field_next = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACK;
                    match_next     = ent_in_reg;
                    status_next    = stat_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_APP_RD:
            begin
                state_next = ST_APP_CHK;
            end
            ST_APP_CHK:
            begin
                if (cram_rdata.mode != MODE_LIST)
                begin
                    stat_next = STAT_NOT_LIST;
                end
                else if (cram_rdata.fill >= FILL_W'(LIST_SLOTS))
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    lram_we         = 1'b1;
                    cram_we         = 1'b1;
                    cram_wdata.fill = FILL_W'(cram_rdata.fill + FILL_W'(1));
                end
                state_next = ST_ACK;
            end
            ST_SCAN_RD:
            begin
                cell_next  = scan_cell;
                state_next = (ent_reg >= scan_limit) ? ST_FINISH : ST_SCAN_EV;
            end
            ST_SCAN_EV, ST_LIST_EV:
            begin
                if (state_reg == ST_SCAN_EV)
                begin
                    fill_next = cram_rdata.fill;
                    slot_next = '0;
                end
                else
                begin
                    slot_next = SLOT_W'(slot_inc);
                end
                if (fld_pass)
                begin
                    if (field_reg == FSEL_W'(FIELDS - 1))
                    begin
                        state_next = ST_HIT;
                    end
                    else
                    begin
                        field_next = FSEL_W'(field_reg + FSEL_W'(1));
                        state_next = ST_SCAN_RD;
                    end
                end
                else if (fld_fail)
                begin
                    ent_next   = SCAN_W'(ent_reg + SCAN_W'(1));
                    base_next  = CELL_W'(base_reg + CELL_W'(FIELDS));
                    field_next = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_LIST_EV;
                end
            end
            ST_HIT:
            begin
                // a held match goes out only once a later match proves it is not the last
                if (!pend_reg || can_load)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_MATCH;
                        match_next     = 4'(pend_ent_reg);
                        status_next    = STAT_OK;
                        last_next      = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_ent_next = ent_reg;
                    ent_next      = SCAN_W'(ent_reg + SCAN_W'(1));
                    base_next     = CELL_W'(base_reg + CELL_W'(FIELDS));
                    field_next    = '0;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = pend_reg ? KIND_MATCH : KIND_NOMATCH;
                    match_next     = pend_reg ? 4'(pend_ent_reg) : 4'd0;
                    status_next    = STAT_OK;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            ent_in_reg    <= '0;
            stat_reg      <= STAT_OK;
            cell_reg      <= '0;
            va_reg        <= '0;
            for (int i = 0; i < FIELDS; i++)
            begin
                tvec_reg[i] <= '0;
            end
            ent_reg       <= '0;
            base_reg      <= '0;
            field_reg     <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_ent_reg  <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_ACK;
            match_reg     <= '0;
            status_reg    <= STAT_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_en)
            begin
                active_reg <= cfg_write_data;
            end
            if (accept)
            begin
                tvec_reg[0] <= VAL_W'(minute);
                tvec_reg[1] <= VAL_W'(hour);
                tvec_reg[2] <= VAL_W'(day);
                tvec_reg[3] <= VAL_W'(month);
                tvec_reg[4] <= VAL_W'(weekday);
            end
            ent_in_reg    <= ent_in_next;
            stat_reg      <= stat_next;
            cell_reg      <= cell_next;
            va_reg        <= va_next;
            ent_reg       <= ent_next;
            base_reg      <= base_next;
            field_reg     <= field_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            pend_ent_reg  <= pend_ent_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            match_reg     <= match_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    // write acknowledges and no-match words always close their item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_ACK || kind == KIND_NOMATCH) |-> last)
        else $error("single result word without last");

    // tick results carry no write status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != KIND_ACK |-> status == STAT_OK)
        else $error("tick result with nonzero status");

    // the scan never evaluates an entry past the active limit
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN_EV || state_reg == ST_HIT |-> ent_reg < scan_limit)
        else $error("scan entry beyond limit");

    // list slots read stay below the cell fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIST_EV |-> FILL_W'(slot_reg) < fill_reg)
        else $error("list slot beyond fill");

    // a match word that is not last is only sent while a later hit is held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && kind == KIND_MATCH && !last |-> pend_reg)
        else $error("non-final match without held hit");

endmodule
